// ----- rtl/icw_pkg.sv -----
package icw_pkg;

    localparam int DEF_WHEEL_SLOTS = 32;
    localparam int DEF_MAX_CONN    = 64;

    localparam int ID_W      = 6;
    localparam int NOW_W     = 32;
    localparam int KIND_W    = 2;
    localparam int CNT_W     = 7;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 16;

    localparam logic OP_TOUCH = 1'b0;
    localparam logic OP_SWEEP = 1'b1;

    typedef enum logic [KIND_W-1:0] {
        KIND_ADDED     = 2'd0,
        KIND_REFRESHED = 2'd1,
        KIND_EVICTED   = 2'd2,
        KIND_NONE      = 2'd3
    } t_kind;

endpackage

// ----- rtl/icw_rem.sv -----
// remainder of a time by the wheel size through a rounded-up reciprocal:
// split product, then quotient low bits, then value - quotient * size on the low bits
module icw_rem #(
    parameter int WHEEL_SLOTS = icw_pkg::DEF_WHEEL_SLOTS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic [icw_pkg::NOW_W-1:0]          i_value,
    output logic                               o_done,
    output logic [$clog2(WHEEL_SLOTS)-1:0]     o_rem
);

    localparam int NW = icw_pkg::NOW_W;
    localparam int SW = $clog2(WHEEL_SLOTS);
    localparam int SH = NW + SW;
    localparam int MW = NW + 1;
    localparam int LW = MW / 2;
    localparam int HW = MW - LW;
    localparam int PW = NW + MW;
    localparam logic [63:0]   P2_SH  = 64'd1 << SH;
    localparam logic [63:0]   DIV_C  = 64'(WHEEL_SLOTS);
    localparam logic [MW-1:0] MAG    = MW'((P2_SH + DIV_C - 64'd1) / DIV_C);
    localparam logic [LW-1:0] MAG_LO = MAG[LW-1:0];
    localparam logic [HW-1:0] MAG_HI = MAG[MW-1:LW];
    localparam logic [SW-1:0] W_LO   = SW'(WHEEL_SLOTS);

    logic [2:0]         r_stage;
    logic               r_done;
    logic [NW-1:0]      r_val;
    logic [NW+LW-1:0]   r_plo;
    logic [NW+HW-1:0]   r_phi;
    logic [SW-1:0]      r_q;
    logic [SW-1:0]      r_rem;
    logic [PW-1:0]      prod;
    logic [SW-1:0]      qw;

    // the remainder is below 2^SW, so only the low bits of the quotient matter
    always_comb begin
        prod = {r_phi, {LW{1'b0}}} + {{HW{1'b0}}, r_plo};
        qw   = r_q * W_LO;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage <= '0;
            r_done  <= 1'b0;
        end else begin
            r_stage <= {r_stage[1:0], i_start};
            r_done  <= r_stage[2];
        end
        if (i_start) begin
            r_val <= i_value;
        end
        r_plo <= {{LW{1'b0}}, r_val} * {{NW{1'b0}}, MAG_LO};
        r_phi <= {{HW{1'b0}}, r_val} * {{NW{1'b0}}, MAG_HI};
        r_q   <= prod[SH+SW-1:SH];
        r_rem <= r_val[SW-1:0] - qw;
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// ----- rtl/icw_mem.sv -----
module icw_mem #(
    parameter int DEPTH = icw_pkg::DEF_MAX_CONN,
    parameter int WIDTH = icw_pkg::NOW_W
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/idle_connection_timing_wheel.sv -----
// channel   dir  tdata (low bit up)                       tuser       tlast
// s_axis    in   conn_id[5:0], now[37:6], pad to 40       operation   -
// m_axis    out  conn_id_out[5:0], evicted_count[12:6]    kind        last
//
// touch and sweep both start with the three-stage reciprocal-multiply remainder unit; a sweep then
// reads one table entry a cycle, unless stalled, through the single read port of the stamp memory.
// the next word is taken in the cycle after the last result is loaded.
// reset clears the present bits and all control; the stamp memory holds
// garbage until written and is only read behind a present bit.
// a full output register stalls the scan only when a second eviction shows up.
module idle_connection_timing_wheel #(
    parameter int WHEEL_SLOTS = icw_pkg::DEF_WHEEL_SLOTS,
    parameter int MAX_CONN    = icw_pkg::DEF_MAX_CONN
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [icw_pkg::S_TDATA_W-1:0]   s_axis_tdata,   // conn_id, now, zeros
    input  logic                            s_axis_tuser,   // operation
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [icw_pkg::M_TDATA_W-1:0]   m_axis_tdata,   // conn_id_out, evicted_count, zeros
    output logic [icw_pkg::KIND_W-1:0]      m_axis_tuser,   // kind
    output logic                            m_axis_tlast
);

    localparam int ID_W  = icw_pkg::ID_W;
    localparam int NOW_W = icw_pkg::NOW_W;
    localparam int CNT_W = icw_pkg::CNT_W;
    localparam int AW    = $clog2(MAX_CONN);
    localparam int IW    = AW + 1;
    localparam int SW    = $clog2(WHEEL_SLOTS);
    localparam int DW    = NOW_W + SW;
    localparam int PAD_W = icw_pkg::M_TDATA_W - ID_W - CNT_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOD,
        S_TWR,
        S_SCAN,
        S_FLUSH
    } t_state;

    t_state                 r_state, n_state;
    logic                   r_op, n_op;
    logic [ID_W-1:0]        r_id, n_id;
    logic [NOW_W-1:0]       r_now, n_now;
    logic [SW-1:0]          r_slot, n_slot;
    logic [MAX_CONN-1:0]    r_present, n_present;
    logic [IW-1:0]          r_rd_idx, n_rd_idx;
    logic                   r_d_vld, n_d_vld;
    logic [AW-1:0]          r_d_idx, n_d_idx;
    logic                   r_pend_vld, n_pend_vld;
    logic [ID_W-1:0]        r_pend_id, n_pend_id;
    logic [CNT_W-1:0]       r_pend_cnt, n_pend_cnt;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic                   r_out_vld, n_out_vld;
    icw_pkg::t_kind         r_out_kind, n_out_kind;
    logic [ID_W-1:0]        r_out_id, n_out_id;
    logic [CNT_W-1:0]       r_out_cnt, n_out_cnt;
    logic                   r_out_last, n_out_last;

    logic                   s_acc;
    logic                   in_op;
    logic [ID_W-1:0]        in_id;
    logic [NOW_W-1:0]       in_now;
    logic                   out_free;
    logic                   rem_start;
    logic                   rem_done;
    logic [SW-1:0]          rem_out;
    logic                   mem_we;
    logic                   mem_re;
    logic [DW-1:0]          mem_rdata;
    logic                   hit;
    logic                   evict;
    logic                   stall;
    logic                   adv;

    assign in_op    = s_axis_tuser;
    assign in_id    = s_axis_tdata[ID_W-1:0];
    assign in_now   = s_axis_tdata[ID_W+NOW_W-1:ID_W];
    assign s_acc    = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_out_vld || m_axis_tready;

    icw_rem #(
        .WHEEL_SLOTS (WHEEL_SLOTS)
    ) u_rem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (rem_start),
        .i_value (in_now),
        .o_done  (rem_done),
        .o_rem   (rem_out)
    );

    icw_mem #(
        .DEPTH (MAX_CONN),
        .WIDTH (DW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_id[AW-1:0]),
        .i_wdata ({r_now, r_slot}),
        .i_re    (mem_re),
        .i_raddr (r_rd_idx[AW-1:0]),
        .o_rdata (mem_rdata)
    );

    // an entry goes when it sits in this slot and was not touched this very second
    assign hit   = (mem_rdata[SW-1:0] == r_slot) && (mem_rdata[DW-1:SW] != r_now);
    assign evict = r_d_vld && r_present[r_d_idx] && hit;
    // the held eviction can only move on if the output register has room
    assign stall = evict && r_pend_vld && !out_free;
    assign adv   = (r_state == S_SCAN) && !stall;
    assign mem_re = adv && (r_rd_idx != IW'(MAX_CONN));

    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        n_id       = r_id;
        n_now      = r_now;
        n_slot     = r_slot;
        n_present  = r_present;
        n_rd_idx   = r_rd_idx;
        n_d_vld    = r_d_vld;
        n_d_idx    = r_d_idx;
        n_pend_vld = r_pend_vld;
        n_pend_id  = r_pend_id;
        n_pend_cnt = r_pend_cnt;
        n_cnt      = r_cnt;
        n_out_vld  = r_out_vld && !m_axis_tready;
        n_out_kind = r_out_kind;
        n_out_id   = r_out_id;
        n_out_cnt  = r_out_cnt;
        n_out_last = r_out_last;
        rem_start  = 1'b0;
        mem_we     = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    n_op  = in_op;
                    n_id  = in_id;
                    n_now = in_now;
                    // touch of an id beyond the table is dropped silently
                    if (!(in_op == icw_pkg::OP_TOUCH &&
                          {1'b0, in_id} >= (ID_W+1)'(MAX_CONN))) begin
                        rem_start = 1'b1;
                        n_state   = S_MOD;
                    end
                end
            end
            S_MOD: begin
                if (rem_done) begin
                    n_slot = rem_out;
                    if (r_op == icw_pkg::OP_TOUCH) begin
                        n_state = S_TWR;
                    end else begin
                        n_rd_idx   = '0;
                        n_d_vld    = 1'b0;
                        n_pend_vld = 1'b0;
                        n_cnt      = '0;
                        n_state    = S_SCAN;
                    end
                end
            end
            S_TWR: begin
                if (out_free) begin
                    mem_we                 = 1'b1;
                    n_present[r_id[AW-1:0]] = 1'b1;
                    n_out_vld  = 1'b1;
                    n_out_kind = r_present[r_id[AW-1:0]] ? icw_pkg::KIND_REFRESHED
                                                         : icw_pkg::KIND_ADDED;
                    n_out_id   = r_id;
                    n_out_cnt  = '0;
                    n_out_last = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_SCAN: begin
                if (adv) begin
                    n_d_vld = mem_re;
                    n_d_idx = r_rd_idx[AW-1:0];
                    if (mem_re) begin
                        n_rd_idx = r_rd_idx + 1'b1;
                    end
                    if (evict) begin
                        n_present[r_d_idx] = 1'b0;
                        n_pend_vld = 1'b1;
                        n_pend_id  = ID_W'(r_d_idx);
                        n_pend_cnt = r_cnt + 1'b1;
                        n_cnt      = r_cnt + 1'b1;
                        // a newer eviction exists, so the held one is not last
                        if (r_pend_vld) begin
                            n_out_vld  = 1'b1;
                            n_out_kind = icw_pkg::KIND_EVICTED;
                            n_out_id   = r_pend_id;
                            n_out_cnt  = r_pend_cnt;
                            n_out_last = 1'b0;
                        end
                    end
                    if (!r_d_vld && r_rd_idx == IW'(MAX_CONN)) begin
                        n_state = S_FLUSH;
                    end
                end
            end
            S_FLUSH: begin
                if (out_free) begin
                    n_out_vld  = 1'b1;
                    n_out_last = 1'b1;
                    if (r_pend_vld) begin
                        n_out_kind = icw_pkg::KIND_EVICTED;
                        n_out_id   = r_pend_id;
                        n_out_cnt  = r_pend_cnt;
                    end else begin
                        n_out_kind = icw_pkg::KIND_NONE;
                        n_out_id   = '0;
                        n_out_cnt  = '0;
                    end
                    n_pend_vld = 1'b0;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_present  <= '0;
            r_d_vld    <= 1'b0;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
            r_rd_idx   <= '0;
            r_cnt      <= '0;
        end else begin
            r_state    <= n_state;
            r_present  <= n_present;
            r_d_vld    <= n_d_vld;
            r_pend_vld <= n_pend_vld;
            r_out_vld  <= n_out_vld;
            r_rd_idx   <= n_rd_idx;
            r_cnt      <= n_cnt;
        end
        r_op       <= n_op;
        r_id       <= n_id;
        r_now      <= n_now;
        r_slot     <= n_slot;
        r_d_idx    <= n_d_idx;
        r_pend_id  <= n_pend_id;
        r_pend_cnt <= n_pend_cnt;
        r_out_kind <= n_out_kind;
        r_out_id   <= n_out_id;
        r_out_cnt  <= n_out_cnt;
        r_out_last <= n_out_last;
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, r_out_cnt, r_out_id};
    assign m_axis_tuser  = r_out_kind;
    assign m_axis_tlast  = r_out_last;

endmodule

// ----- rtl/icw_chk.sv -----
module icw_chk (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            s_axis_tuser,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [icw_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    input logic [icw_pkg::KIND_W-1:0]      m_axis_tuser,
    input logic                            m_axis_tlast
);

    localparam int CLO = icw_pkg::ID_W;
    localparam int CHI = icw_pkg::ID_W + icw_pkg::CNT_W - 1;

    // a stalled word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
            $stable(m_axis_tlast))
        else $error("output word changed while stalled");

    // empty sweep reports a single zero word
    a_none_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == icw_pkg::KIND_NONE |->
            m_axis_tlast && m_axis_tdata == '0)
        else $error("empty sweep word malformed");

    a_touch_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == icw_pkg::KIND_ADDED ||
                          m_axis_tuser == icw_pkg::KIND_REFRESHED) |->
            m_axis_tlast && m_axis_tdata[CHI:CLO] == '0)
        else $error("touch word carries a count or lacks last");

    a_evict_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == icw_pkg::KIND_EVICTED |->
            m_axis_tdata[CHI:CLO] != '0)
        else $error("eviction word with zero count");

    // a sweep always takes the block busy for the scan
    a_sweep_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser == icw_pkg::OP_SWEEP |=>
            !s_axis_tready)
        else $error("input taken during a sweep");

endmodule

bind idle_connection_timing_wheel icw_chk u_icw_chk (.*);
